// File: hdl/lpc_pkg.sv
// shared types and constants for the lru page cache
// no dependencies; every other file imports this package
package lpc_pkg;

    // storage geometry
    localparam int ENTRIES   = 8;
    localparam int DATA_BITS = 64;

    // fixed field widths
    localparam int MODE_W    = 2;
    localparam int KEY_W     = 32;
    localparam int IN_DATA_W = 64;
    localparam int OUT_W     = 64;
    localparam int CAP_W     = 4;

    // derived widths
    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = 8;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD      = 2'd0,
        MODE_GET      = 2'd1,
        MODE_REMOVE   = 2'd2,
        MODE_CONTAINS = 2'd3
    } mode_t;

    // request presented to the engine
    typedef struct packed {
        logic                 fire;
        mode_t                mode;
        logic [KEY_W-1:0]     key;
        logic [DATA_BITS-1:0] data;
    } req_t;

    // result computed by the engine
    typedef struct packed {
        logic             hit;
        logic [OUT_W-1:0] data;
    } rsp_t;

    // occupancy status of the entry array
    typedef struct packed {
        logic [ENTRIES-1:0] valid_vec;
        logic [CNT_W-1:0]   count;
    } status_t;

endpackage

// File: hdl/lpc_if.sv
// channel interfaces of the lru page cache: request, response, config write
// depends on lpc_pkg for field widths
interface lpc_req_if
    import lpc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [KEY_W-1:0]     page_key;
    logic [IN_DATA_W-1:0] page_data;

    modport source (output valid, output mode, output page_key, output page_data, input ready);
    modport sink   (input valid, input mode, input page_key, input page_data, output ready);
endinterface

interface lpc_rsp_if
    import lpc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             hit;
    logic [OUT_W-1:0] data_out;

    modport source (output valid, output hit, output data_out, input ready);
    modport sink   (input valid, input hit, input data_out, output ready);
endinterface

interface lpc_cfg_if
    import lpc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

// File: hdl/lpc_engine.sv
// entry array of the lru page cache with combinational lookup and registered recency update
// depends on lpc_pkg
module lpc_engine
    import lpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  req_t             req,
    input  logic [CAP_W-1:0] capacity,
    output rsp_t             rsp,
    output status_t          status
);

    // entry storage
    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [KEY_W-1:0]     key_reg  [ENTRIES];
    logic [DATA_BITS-1:0] data_reg [ENTRIES];
    logic [RANK_W-1:0]    rank_reg [ENTRIES];
    logic [RANK_W-1:0]    rank_next[ENTRIES];

    // lookup
    logic [ENTRIES-1:0]   hit_vec;
    logic                 hit;
    logic [DATA_BITS-1:0] hit_data;
    logic [RANK_W-1:0]    hit_rank;

    // replacement
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               evict;
    logic [CNT_W-1:0]   top_cnt;
    logic [RANK_W-1:0]  top_rank;
    logic [ENTRIES-1:0] victim_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] slot_vec;

    logic do_add;
    logic do_promote;
    logic do_drop;
    logic do_insert;

    // parallel key compare and one-hot read of the matching entry
    always_comb
    begin
        hit_data = '0;
        hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_reg[i] == req.key);
            if (hit_vec[i])
            begin
                hit_data = hit_data | data_reg[i];
                hit_rank = hit_rank | rank_reg[i];
            end
        end
        hit = |hit_vec;
    end

    // clamp the capacity and find the least recent entry
    always_comb
    begin
        cap_ext = CMP_W'(capacity);
        if (cap_ext == '0)
            eff_cap = CMP_W'(1);
        else if (cap_ext > CMP_W'(ENTRIES))
            eff_cap = CMP_W'(ENTRIES);
        else
            eff_cap = cap_ext;
        evict    = CMP_W'(count_reg) >= eff_cap;
        top_cnt  = count_reg - CNT_W'(1);
        top_rank = RANK_W'(top_cnt);
        for (int i = 0; i < ENTRIES; i++)
            victim_vec[i] = valid_reg[i] && (rank_reg[i] == top_rank);
        free_vec = ~valid_reg | (evict ? victim_vec : '0);
        slot_vec = free_vec & (~free_vec + ENTRIES'(1));
    end

    // operation decode
    always_comb
    begin
        do_add     = 1'b0;
        do_promote = 1'b0;
        do_drop    = 1'b0;
        unique case (req.mode)
            MODE_ADD:
            begin
                do_add     = req.fire;
                do_promote = req.fire && hit;
            end
            MODE_GET:
            begin
                do_promote = req.fire && hit;
            end
            MODE_REMOVE:
            begin
                do_drop = req.fire && hit;
            end
            default:
            begin
                do_add = 1'b0;
            end
        endcase
        do_insert = do_add && !hit;
    end

    // next valid bits, ranks and count
    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++)
            rank_next[i] = rank_reg[i];
        if (do_promote)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (hit_vec[i])
                    rank_next[i] = '0;
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
            end
        end
        else if (do_drop)
        begin
            valid_next = valid_reg & ~hit_vec;
            count_next = count_reg - CNT_W'(1);
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (valid_reg[i] && (rank_reg[i] > hit_rank))
                    rank_next[i] = rank_reg[i] - RANK_W'(1);
            end
        end
        else if (do_insert)
        begin
            // the victim holds the top rank, so no entry moves down on eviction
            valid_next = (valid_reg & ~(evict ? victim_vec : '0)) | slot_vec;
            count_next = evict ? count_reg : count_reg + CNT_W'(1);
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot_vec[i])
                    rank_next[i] = '0;
                else if (valid_reg[i])
                    rank_next[i] = rank_reg[i] + RANK_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_reg[i] <= rank_next[i];
            if (do_insert && slot_vec[i])
                key_reg[i] <= req.key;
            if ((do_add && hit_vec[i]) || (do_insert && slot_vec[i]))
                data_reg[i] <= req.data;
        end
    end

    // result of this transfer
    always_comb
    begin
        rsp.hit  = hit;
        rsp.data = (req.mode == MODE_GET && hit) ? OUT_W'(hit_data) : '0;
    end

    assign status.valid_vec = valid_reg;
    assign status.count     = count_reg;

endmodule

// File: hdl/lru_page_cache_core.sv
// top level of the lru page cache: input register, engine, result register
// depends on lpc_pkg, lpc_if and lpc_engine
//
// Channels: req (mode, page_key, page_data) in, rsp (hit, data_out) out,
// cfg writes the 4-bit capacity. Each transfer completes when valid and
// ready are both high at a rising edge of clk.
// One result comes back for every request, in order. A request passes
// the input register and then the result register, where rsp.valid rises,
// so the response transfer comes after both at the earliest. Throughput
// is one request per cycle while rsp is not stalled, set by the
// combinational key compare and recency update across all eight entries,
// which the next request sees at once.
// When rsp is stalled, the result register holds, the input register fills
// and then req.ready drops; nothing is lost or repeated.
// Reset (rst_n low, asynchronous) empties the cache and sets capacity to 8.
// cfg.ready is always high; write capacity only while the block is idle.
module lru_page_cache_core
    import lpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lpc_req_if.sink   req,
    lpc_rsp_if.source rsp,
    lpc_cfg_if.sink   cfg
);

    // input register
    logic                 s1_valid_reg;
    logic [MODE_W-1:0]    s1_mode_reg;
    logic [KEY_W-1:0]     s1_key_reg;
    logic [DATA_BITS-1:0] s1_data_reg;

    // result register
    logic             out_valid_reg;
    logic             out_hit_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic [CAP_W-1:0] cap_reg;

    logic    process;
    req_t    eng_req;
    rsp_t    eng_rsp;
    status_t eng_status;

    // the held request executes when the result register can take it
    assign process   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || process;
    assign cfg.ready = 1'b1;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg.valid && cfg.ready)
            cap_reg <= cfg.capacity;
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.valid && req.ready)
            s1_valid_reg <= 1'b1;
        else if (process)
            s1_valid_reg <= 1'b0;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_mode_reg <= req.mode;
            s1_key_reg  <= req.page_key;
            s1_data_reg <= DATA_BITS'(req.page_data);
        end
    end

    // engine
    always_comb
    begin
        eng_req.fire = process;
        eng_req.mode = mode_t'(s1_mode_reg);
        eng_req.key  = s1_key_reg;
        eng_req.data = s1_data_reg;
    end

    lpc_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (eng_req),
        .capacity (cap_reg),
        .rsp      (eng_rsp),
        .status   (eng_status)
    );

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (process)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_hit_reg  <= eng_rsp.hit;
            out_data_reg <= eng_rsp.data;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.hit      = out_hit_reg;
    assign rsp.data_out = out_data_reg;

`ifndef SYNTHESIS
    // occupancy count tracks the valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        eng_status.count == CNT_W'($countones(eng_status.valid_vec)))
        else $error("valid count differs from number of valid entries");

    // a held request that cannot execute stays held
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !process |=> s1_valid_reg)
        else $error("held request lost while result register was busy");

    // data is returned only on a hit
    a_data_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_hit_reg |-> out_data_reg == '0)
        else $error("nonzero data returned on a miss");
`endif

endmodule
